@@ design/ssed_pkg.sv @@
package ssed_pkg;

  localparam int CMD_W       = 2;
  localparam int IN_INDEX_W  = 20;
  localparam int VALUE_W     = 24;
  localparam int SUM_W       = 60;
  localparam int DIFF_W      = VALUE_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int QUEUE_DEPTH = 4;

  localparam int DEF_MAX_ENTRIES = 256;
  localparam int DEF_INDEX_BITS  = 20;

  localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ design/ssed_queue.sv @@
module ssed_queue #(
  parameter int W = 46
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [W-1:0]    wdata,
  input  logic            pop,
  output logic [W-1:0]    rdata,
  output ssed_pkg::qstat_t stat
);
  import ssed_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slots_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] fill_r, fill_nxt;

  assign stat.full  = (fill_r == NW'(QUEUE_DEPTH));
  assign stat.empty = (fill_r == '0);
  assign rdata      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ design/ssed_front.sv @@
module ssed_front #(
  parameter int INDEX_BITS = 20
) (
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ssed_pkg::CMD_W-1:0]            in_command,
  input  logic [ssed_pkg::IN_INDEX_W-1:0]       in_entry_index,
  input  logic signed [ssed_pkg::VALUE_W-1:0]   in_entry_value,
  input  ssed_pkg::qstat_t                      q_stat,
  output logic                                  q_push,
  output logic [ssed_pkg::CMD_W+INDEX_BITS+ssed_pkg::VALUE_W-1:0] q_wdata
);
  import ssed_pkg::*;

  logic [INDEX_BITS-1:0] idx;
  logic                  useful;

  // Take the index modulo 2^INDEX_BITS, zero-extend when wider.
  always_comb begin
    idx = '0;
    for (int k = 0; k < INDEX_BITS; k++) begin
      if (k < IN_INDEX_W) begin
        idx[k] = in_entry_index[k];
      end
    end
  end

  // Drop the unused command at the door.
  assign useful   = in_command inside {CMD_APPEND_A, CMD_APPEND_B, CMD_COMPUTE};
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full && useful;
  assign q_wdata  = {in_command, idx, in_entry_value};

endmodule

@@ design/ssed_back.sv @@
module ssed_back #(
  parameter int MAX_ENTRIES = 256,
  parameter int INDEX_BITS  = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ssed_pkg::qstat_t                      q_stat,
  input  logic [ssed_pkg::CMD_W+INDEX_BITS+ssed_pkg::VALUE_W-1:0] q_rdata,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ssed_pkg::SUM_W-1:0]            out_squared_distance,
  output logic                                  out_overflow_flag
);
  import ssed_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = INDEX_BITS + VALUE_W;
  localparam int QW = CMD_W + EW;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RD    = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic          drop_r, drop_nxt;
  logic          d_vld_r, d_vld_nxt, sq_vld_r;
  logic          out_valid_r, out_valid_nxt;
  logic          sat_r;

  logic [EW-1:0] mem_a [MAX_ENTRIES];
  logic [EW-1:0] mem_b [MAX_ENTRIES];
  logic [EW-1:0] rd_a_r, rd_b_r;

  logic signed [DIFF_W-1:0] d_r, d_nxt;
  logic [SQ_W-1:0]          sq_r;
  logic [SUM_W-1:0]         acc_r;
  logic [SUM_W-1:0]         out_sum_r;
  logic                     out_ovf_r;

  logic [CMD_W-1:0] cmd;
  logic [EW-1:0]    ent;
  logic             wr_a, wr_b, start, rd_en, fin;
  logic             has_a, has_b, take_a, take_b;
  logic [INDEX_BITS-1:0]    ia, ib;
  logic signed [DIFF_W-1:0] va, vb;
  logic [DIFF_W-1:0]        mag;
  logic [SUM_W:0]           sum;

  assign cmd   = q_rdata[QW-1 -: CMD_W];
  assign ent   = q_rdata[EW-1:0];
  assign q_pop = (state_r == ST_IDLE) && !q_stat.empty;
  assign wr_a  = q_pop && (cmd == CMD_APPEND_A) && (cnt_a_r < FULL_CNT);
  assign wr_b  = q_pop && (cmd == CMD_APPEND_B) && (cnt_b_r < FULL_CNT);
  assign start = q_pop && (cmd == CMD_COMPUTE);
  assign rd_en = (state_r == ST_RD);
  assign fin   = (state_r == ST_DRAIN) && !d_vld_r && !sq_vld_r
                 && (!out_valid_r || !out_stall);

  // Merge step on the heads read last cycle.
  always_comb begin
    has_a  = (i_r < cnt_a_r);
    has_b  = (j_r < cnt_b_r);
    ia     = rd_a_r[EW-1:VALUE_W];
    ib     = rd_b_r[EW-1:VALUE_W];
    va     = DIFF_W'($signed(rd_a_r[VALUE_W-1:0]));
    vb     = DIFF_W'($signed(rd_b_r[VALUE_W-1:0]));
    take_a = 1'b0;
    take_b = 1'b0;
    if (has_a && has_b) begin
      take_a = (ia <= ib);
      take_b = (ia >= ib);
    end else if (has_a) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
    end
    d_nxt = (take_a ? va : '0) - (take_b ? vb : '0);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    drop_nxt      = drop_r;
    d_vld_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          if (wr_a) begin
            cnt_a_nxt = cnt_a_r + 1'b1;
          end else if (wr_b) begin
            cnt_b_nxt = cnt_b_r + 1'b1;
          end else if (start) begin
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = (cnt_a_r == '0 && cnt_b_r == '0) ? ST_DRAIN : ST_RD;
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        d_vld_nxt = 1'b1;
        i_nxt     = i_r + CW'(take_a);
        j_nxt     = j_r + CW'(take_b);
        state_nxt = (i_nxt >= cnt_a_r && j_nxt >= cnt_b_r) ? ST_DRAIN : ST_RD;
      end
      ST_DRAIN: begin
        if (fin) begin
          out_valid_nxt = 1'b1;
          cnt_a_nxt     = '0;
          cnt_b_nxt     = '0;
          drop_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      drop_r      <= 1'b0;
      d_vld_r     <= 1'b0;
      sq_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      drop_r      <= drop_nxt;
      d_vld_r     <= d_vld_nxt;
      sq_vld_r    <= d_vld_r;
      out_valid_r <= out_valid_nxt;
      if (start) begin
        acc_r <= '0;
        sat_r <= 1'b0;
      end else if (sq_vld_r) begin
        if (sum[SUM_W]) begin
          acc_r <= '1;
          sat_r <= 1'b1;
        end else begin
          acc_r <= sum[SUM_W-1:0];
        end
      end
    end
  end

  // Vector stores, one write and one registered read port each.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[AW-1:0]] <= ent;
    end
    if (wr_b) begin
      mem_b[cnt_b_r[AW-1:0]] <= ent;
    end
    if (rd_en) begin
      rd_a_r <= mem_a[i_r[AW-1:0]];
      rd_b_r <= mem_b[j_r[AW-1:0]];
    end
  end

  assign mag = d_r[DIFF_W-1] ? DIFF_W'(-d_r) : DIFF_W'(d_r);
  assign sum = {1'b0, acc_r} + (SUM_W + 1)'(sq_r);

  always_ff @(posedge clk) begin
    if (d_vld_nxt) begin
      d_r <= d_nxt;
    end
    if (d_vld_r) begin
      sq_r <= mag * mag;
    end
    if (fin) begin
      out_sum_r <= acc_r;
      out_ovf_r <= sat_r | drop_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_squared_distance = out_sum_r;
  assign out_overflow_flag    = out_ovf_r;

endmodule

@@ design/sparse_squared_euclidean_distance.sv @@
// Channel | Direction | Fields                                   | Handshake
// in      | input     | command, entry_index, entry_value        | in_valid / in_stall
// out     | output    | squared_distance, overflow_flag          | out_valid / out_stall
//
// Appends are popped by the back end while it is idle; a four-deep queue lets the
// input keep taking transactions while a compute runs.
// A compute leaves the queue, then runs merge steps (registered store read,
// then compare), at most cnt_a + cnt_b steps, and then drains the square and
// accumulate stages; with both vectors empty it goes straight to the drain.
// The result is registered when the drain ends and shows in the cycle after.
// Reset (synchronous, rst_n low) empties the queue, counts and output.
// The result holds in the output register until out_stall drops.
module sparse_squared_euclidean_distance #(
  parameter int MAX_ENTRIES = ssed_pkg::DEF_MAX_ENTRIES,
  parameter int INDEX_BITS  = ssed_pkg::DEF_INDEX_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ssed_pkg::CMD_W-1:0]          in_command,
  input  logic [ssed_pkg::IN_INDEX_W-1:0]     in_entry_index,
  input  logic signed [ssed_pkg::VALUE_W-1:0] in_entry_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ssed_pkg::SUM_W-1:0]          out_squared_distance,
  output logic                                out_overflow_flag
);
  import ssed_pkg::*;

  localparam int QW = CMD_W + INDEX_BITS + VALUE_W;

  qstat_t        q_stat;
  logic          q_push, q_pop;
  logic [QW-1:0] q_wdata, q_rdata;

  // Front: classify the transaction and drop unused commands.
  ssed_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // Queue: decouple the front from the merge engine.
  ssed_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: store entries, merge-walk on compute, hold the result.
  ssed_back #(.MAX_ENTRIES(MAX_ENTRIES), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_stat               (q_stat),
    .q_rdata              (q_rdata),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_squared_distance (out_squared_distance),
    .out_overflow_flag    (out_overflow_flag)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_no_dead_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata[QW-1 -: CMD_W] != CMD_NONE))
    else $error("unused command queued");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !q_pop) |=> q_stat.full)
    else $error("queue lost an entry");

endmodule

@@ dv/sparse_squared_euclidean_distance_test.sv @@
`timescale 1ns / 100ps

module sparse_squared_euclidean_distance_test;
  import ssed_pkg::*;

  localparam int CAPACITY = DEF_MAX_ENTRIES;
  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [IN_INDEX_W-1:0]     entry_index;
    logic signed [VALUE_W-1:0] entry_value;
  } entry_t;

  typedef struct packed {
    logic [SUM_W-1:0] squared_distance;
    logic             overflow_flag;
  } distance_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_command = CMD_NONE;
  logic [IN_INDEX_W-1:0]     in_entry_index = '0;
  logic signed [VALUE_W-1:0] in_entry_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [SUM_W-1:0]          out_squared_distance;
  logic                      out_overflow_flag;

  sparse_squared_euclidean_distance i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_entry_index       (in_entry_index),
    .in_entry_value       (in_entry_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_squared_distance (out_squared_distance),
    .out_overflow_flag    (out_overflow_flag)
  );

  // Shadow copy of the two sparse vectors
  logic [IN_INDEX_W-1:0]     vec_a_index [CAPACITY];
  logic signed [VALUE_W-1:0] vec_a_value [CAPACITY];
  logic [IN_INDEX_W-1:0]     vec_b_index [CAPACITY];
  logic signed [VALUE_W-1:0] vec_b_value [CAPACITY];
  int                        vec_a_count = 0;
  int                        vec_b_count = 0;
  logic                      entries_dropped = 1'b0;

  entry_t    pending_entries[$];
  distance_t expected_distances[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int distances_checked;
  int entries_sent;
  bit stimulus_done;
  bit in_taken;

  // Append one transaction to the pending list.
  function automatic void queue_entry(entry_t e);
    pending_entries.insert(pending_entries.size(), e);
  endfunction

  // Add the square of one value, saturating at the 60-bit maximum.
  function automatic void add_square(inout logic [SUM_W-1:0] acc, inout logic sat,
                                     input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] mag;
    logic [SUM_W-1:0]  sq;
    mag = d[DIFF_W-1] ? -d : d;
    sq = SUM_W'(mag) * SUM_W'(mag);
    if (acc > SUM_LIMIT - sq) begin
      acc = SUM_LIMIT;
      sat = 1'b1;
    end else begin
      acc = acc + sq;
    end
  endfunction

  // Merge-walk both vectors in stored order and sum the squared differences.
  function automatic distance_t merge_distance();
    distance_t r;
    logic [SUM_W-1:0] acc;
    logic sat;
    int i;
    int j;
    acc = '0;
    sat = 1'b0;
    i = 0;
    j = 0;
    while (i < vec_a_count || j < vec_b_count) begin
      if (i >= vec_a_count) begin
        add_square(acc, sat, DIFF_W'(vec_b_value[j]));
        j++;
      end else if (j >= vec_b_count) begin
        add_square(acc, sat, DIFF_W'(vec_a_value[i]));
        i++;
      end else if (vec_a_index[i] < vec_b_index[j]) begin
        add_square(acc, sat, DIFF_W'(vec_a_value[i]));
        i++;
      end else if (vec_a_index[i] > vec_b_index[j]) begin
        add_square(acc, sat, DIFF_W'(vec_b_value[j]));
        j++;
      end else begin
        add_square(acc, sat, DIFF_W'(vec_a_value[i]) - DIFF_W'(vec_b_value[j]));
        i++;
        j++;
      end
    end
    r.squared_distance = acc;
    r.overflow_flag = sat | entries_dropped;
    return r;
  endfunction

  // Update the shadow vectors for one accepted transaction.
  function automatic void apply_entry(entry_t e);
    case (e.command)
      CMD_APPEND_A: begin
        if (vec_a_count < CAPACITY) begin
          vec_a_index[vec_a_count] = e.entry_index;
          vec_a_value[vec_a_count] = e.entry_value;
          vec_a_count++;
        end else begin
          entries_dropped = 1'b1;
        end
      end
      CMD_APPEND_B: begin
        if (vec_b_count < CAPACITY) begin
          vec_b_index[vec_b_count] = e.entry_index;
          vec_b_value[vec_b_count] = e.entry_value;
          vec_b_count++;
        end else begin
          entries_dropped = 1'b1;
        end
      end
      CMD_COMPUTE: begin
        expected_distances.insert(expected_distances.size(), merge_distance());
        vec_a_count = 0;
        vec_b_count = 0;
        entries_dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: present the head of the queue, advance it on acceptance.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_entries.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid       <= 1'b1;
        in_command     <= pending_entries[0].command;
        in_entry_index <= pending_entries[0].entry_index;
        in_entry_value <= pending_entries[0].entry_value;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Predict on each accepted transaction.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      apply_entry(pending_entries.pop_front());
      entries_sent++;
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    distance_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_distances.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result %0h flag %0b",
                   out_squared_distance, out_overflow_flag);
      end else begin
        want = expected_distances.pop_front();
        distances_checked++;
        if (want.squared_distance !== out_squared_distance ||
            want.overflow_flag !== out_overflow_flag) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: distance exp %0h act %0h, flag exp %0b act %0b",
                     want.squared_distance, out_squared_distance,
                     want.overflow_flag, out_overflow_flag);
        end
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      2: return VALUE_W'(int'($urandom_range(255)) - 128);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic entry_t make_entry(logic [CMD_W-1:0] c, int unsigned idx,
                                        logic signed [VALUE_W-1:0] v);
    entry_t e;
    e.command = c;
    e.entry_index = IN_INDEX_W'(idx);
    e.entry_value = v;
    return e;
  endfunction

  // Queue a pair of vectors, sorted if asked, plus a compute.
  task automatic queue_vector_pair(int len_a, int len_b, bit sorted);
    int unsigned idx_a;
    int unsigned idx_b;
    int unsigned step;
    idx_a = $urandom_range(3);
    idx_b = idx_a;
    step = ($urandom_range(3) == 0) ? 4096 : 3;
    for (int k = 0; k < len_a || k < len_b; k++) begin
      if (k < len_a) begin
        queue_entry(make_entry(CMD_APPEND_A,
          sorted ? idx_a : $urandom, rand_value()));
        idx_a += $urandom_range(step);
      end
      if (k < len_b) begin
        queue_entry(make_entry(CMD_APPEND_B,
          sorted ? idx_b : $urandom, rand_value()));
        idx_b += $urandom_range(step);
      end
      if ($urandom_range(30) == 0)
        queue_entry(make_entry(CMD_NONE, $urandom, VALUE_W'($urandom)));
    end
    queue_entry(make_entry(CMD_COMPUTE, $urandom, VALUE_W'($urandom)));
  endtask

  // Wait until the queue and all expectations have drained.
  task automatic drain();
    while (pending_entries.size() > 0 || expected_distances.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall[4];
    phase_idle  = '{0, 57, 0, 26};
    phase_stall = '{0, 0, 57, 26};
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty compute, extremes, tie, unsorted, unused command.
    queue_entry(make_entry(CMD_COMPUTE, 0, '0));
    queue_entry(make_entry(CMD_APPEND_A, 0, {1'b1, 23'd0}));
    queue_entry(make_entry(CMD_APPEND_B, 0, {1'b0, {23{1'b1}}}));
    queue_entry(make_entry(CMD_APPEND_A, 20'hFFFFF, {1'b0, {23{1'b1}}}));
    queue_entry(make_entry(CMD_NONE, 20'hFFFFF, '1));
    queue_entry(make_entry(CMD_COMPUTE, 20'hFFFFF, '1));
    queue_entry(make_entry(CMD_APPEND_B, 7, 24'h000100));
    queue_entry(make_entry(CMD_APPEND_B, 2, -24'sd5));
    queue_entry(make_entry(CMD_APPEND_A, 2, 24'h0000FF));
    queue_entry(make_entry(CMD_APPEND_A, 1, -24'sd1));
    queue_entry(make_entry(CMD_COMPUTE, 0, '0));
    queue_entry(make_entry(CMD_APPEND_B, 20'h55555, 24'hAAAAAA));
    queue_entry(make_entry(CMD_COMPUTE, 20'hAAAAA, 24'h555555));
    drain();

    // Random phases; two of them also overflow one vector past its capacity.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      while (pending_entries.size() < 220) begin
        if ($urandom_range(7) == 0)
          queue_vector_pair($urandom_range(4), $urandom_range(4), 1'b0);
        else
          queue_vector_pair($urandom_range(12), $urandom_range(12), 1'b1);
      end
      drain();
      if (p == 1 || p == 2) begin
        for (int k = 0; k < CAPACITY + 2; k++)
          queue_entry(make_entry(p[0] ? CMD_APPEND_B : CMD_APPEND_A,
                                 k, {1'b1, 23'd0}));
        queue_entry(make_entry(CMD_COMPUTE, 0, '0));
        drain();
      end
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    $display("Covered %0d transactions and %0d distance results, %0d mismatches.",
             entries_sent, distances_checked, mismatch_count);
    if (mismatch_count == 0 && expected_distances.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
design/ssed_pkg.sv
design/ssed_queue.sv
design/ssed_front.sv
design/ssed_back.sv
design/sparse_squared_euclidean_distance.sv
dv/sparse_squared_euclidean_distance_test.sv
